### src/least_loaded_dispatcher_defines.svh
// Assertion macros for the least-loaded dispatcher checker.
// Every macro samples on clock; the first two are disabled during reset.
`ifndef LEAST_LOADED_DISPATCHER_DEFINES_SVH
`define LEAST_LOADED_DISPATCHER_DEFINES_SVH

// same-cycle implication
`define LLD_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lld_checker: same-cycle property failed");

// next-cycle implication
`define LLD_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lld_checker: next-cycle property failed");

// next-cycle implication that also holds across reset
`define LLD_ASSERT_RST(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("lld_checker: reset property failed");

`endif

### src/lld_pkg.sv
// Shared types, codes and defaults of the least-loaded dispatcher.
// No dependencies; imported by the top level, the sequencer and the checker.
`default_nettype none

package lld_pkg;

   localparam int MAX_WORKERS_DEF = 16;
   localparam int LOAD_BITS_DEF   = 10;

   localparam int QUEUE_BITS  = 11;
   localparam int CHOSEN_BITS = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 11;

   // commands
   localparam logic [1:0] CMD_DISPATCH = 2'd0;
   localparam logic [1:0] CMD_REPORT   = 2'd1;
   localparam logic [1:0] CMD_DEQUEUE  = 2'd2;

   // outcomes
   localparam logic [2:0] OC_OK        = 3'd0;
   localparam logic [2:0] OC_INVALID   = 3'd1;
   localparam logic [2:0] OC_INACTIVE  = 3'd2;
   localparam logic [2:0] OC_ALL_FULL  = 3'd3;
   localparam logic [2:0] OC_RING_FULL = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_WORKERS  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLIND_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RING_LIMIT      = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_ENABLED    = 2'd3;

   // register reset values
   localparam logic [4:0]  ACTIVE_WORKERS_RST  = 5'd1;
   localparam logic [9:0]  BLIND_THRESHOLD_RST = 10'd0;
   localparam logic [10:0] RING_LIMIT_RST      = 11'd32;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] client_handle;
      logic [3:0]         worker_index;
      logic [9:0]         busy_count;
      logic               full_mark;
   } req_type;

   typedef struct packed {
      logic [2:0]               outcome;
      logic [CHOSEN_BITS-1:0]   chosen_worker;
      logic signed [15:0]       client_out;
      logic                     pool_full;
   } rsp_type;

   typedef struct packed {
      logic [4:0]            active_workers;
      logic [9:0]            blind_threshold;
      logic [QUEUE_BITS-1:0] ring_limit;
      logic                  pool_enabled;
   } cfg_type;

endpackage

`default_nettype wire

### src/least_loaded_dispatcher.sv
// Least-loaded dispatcher: top level, configuration registers, result register.
// Depends on lld_pkg, lld_mem and lld_ctrl.
//
// Usage
//  - req_* channel: one item per handshake. A dispatch picks a worker; a load
//    report or dequeue updates one worker's table entry. Every item yields
//    exactly one result item on the rsp_* channel, in order.
//  - csr_* channel: register writes (index, data), always ready. Write only
//    while the block is idle.
//  - One item is in work at a time. A dispatch over N taking-part workers
//    goes through a scan that reads one table entry per cycle from the worker
//    memory (ending early when a worker below the blind threshold turns up),
//    then a decide step and the result state. Updates go through one
//    read-modify-write state; rejected dispatches go straight to the result
//    state. The next item is taken in the cycle after the result moves out.
//  - A result waiting in the output register does not block the next item;
//    if the receiver stalls, the following result waits inside the
//    sequencer and req_ready stays low until the output register frees.
//  - Reset: synchronous, active high. Registers return to their defaults,
//    the pool-full latch clears and every worker entry reads as zero.
`default_nettype none

module least_loaded_dispatcher #(
   parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF,
   parameter int LOAD_BITS   = lld_pkg::LOAD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lld_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lld_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lld_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [lld_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import lld_pkg::*;

   localparam int WIDX_BITS = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int ENT_BITS  = LOAD_BITS + QUEUE_BITS + 1;

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                 res_valid;
   rsp_type              res_data;
   logic                 res_take;
   logic                 rd_en;
   logic [WIDX_BITS-1:0] rd_addr;
   logic [ENT_BITS-1:0]  rd_data;
   logic                 wr_en;
   logic [WIDX_BITS-1:0] wr_addr;
   logic [ENT_BITS-1:0]  wr_data;

   // configuration: always ready, each register keeps its own low bits
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_WORKERS:  cfg_in.active_workers  = csr_data[4:0];
            CSR_BLIND_THRESHOLD: cfg_in.blind_threshold = csr_data[9:0];
            CSR_RING_LIMIT:      cfg_in.ring_limit      = csr_data[QUEUE_BITS-1:0];
            CSR_POOL_ENABLED:    cfg_in.pool_enabled    = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // output register: loads when empty or being emptied this cycle
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_workers  <= ACTIVE_WORKERS_RST;
         cfg_ff.blind_threshold <= BLIND_THRESHOLD_RST;
         cfg_ff.ring_limit      <= RING_LIMIT_RST;
         cfg_ff.pool_enabled    <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lld_ctrl #(
      .MAX_WORKERS (MAX_WORKERS),
      .LOAD_BITS   (LOAD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_take  (res_take),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // worker table: {full flag, queued count, active count} per worker
   lld_mem #(
      .DEPTH (MAX_WORKERS),
      .WIDTH (ENT_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

`default_nettype wire

### src/lld_mem.sv
// Worker table: single-port-write, single-port-read memory, registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
`default_nettype none

module lld_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 22
) (
   input  logic clock,
   input  logic reset,
   input  logic rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_vld_ff;
   logic [DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // an entry never written since reset reads as all zero
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

### src/lld_ctrl.sv
// Sequencer: checks, table scan, read-modify-write of the chosen entry.
// Uses lld_pkg; drives the lld_mem ports and hands results to the top level.
`default_nettype none

module lld_ctrl #(
   parameter int MAX_WORKERS = 16,
   parameter int LOAD_BITS   = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  lld_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  lld_pkg::req_type req_data,
   output logic             res_valid,
   output lld_pkg::rsp_type res_data,
   input  logic             res_take,
   output logic             rd_en,
   output logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] rd_addr,
   input  logic [LOAD_BITS+lld_pkg::QUEUE_BITS:0] rd_data,
   output logic             wr_en,
   output logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] wr_addr,
   output logic [LOAD_BITS+lld_pkg::QUEUE_BITS:0] wr_data
);
   import lld_pkg::*;

   localparam int WIDX_BITS = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_WORKERS + 1);
   localparam int ENT_BITS  = LOAD_BITS + QUEUE_BITS + 1;
   localparam int SUM_BITS  = ((LOAD_BITS > QUEUE_BITS) ? LOAD_BITS : QUEUE_BITS) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPD,
      ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   rsp_type               res_ff, res_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [WIDX_BITS-1:0]  chk_ff, chk_in;
   logic [WIDX_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [SUM_BITS-1:0]   best_load_ff, best_load_in;
   logic [ENT_BITS-1:0]   best_ent_ff, best_ent_in;
   logic                  found_ff, found_in;
   logic                  latch_ff, latch_in;

   logic                  accept;
   logic [LOAD_BITS-1:0]  ent_active;
   logic [QUEUE_BITS-1:0] ent_queued;
   logic                  ent_full;
   logic [SUM_BITS-1:0]   ent_load;
   logic                  blind_hit;
   logic                  better;
   logic                  last;
   logic [CNT_BITS-1:0]   cnt_clamp;
   logic                  in_range;
   logic [QUEUE_BITS-1:0] best_queued;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign ent_active = rd_data[LOAD_BITS-1:0];
   assign ent_queued = rd_data[LOAD_BITS +: QUEUE_BITS];
   assign ent_full   = rd_data[ENT_BITS-1];
   assign ent_load   = SUM_BITS'(ent_active) + SUM_BITS'(ent_queued);
   assign blind_hit  = !ent_full && (ent_load < SUM_BITS'(cfg.blind_threshold));
   assign better     = !ent_full && (!found_ff || (ent_load < best_load_ff));
   assign last       = (CNT_BITS'(chk_ff) + CNT_BITS'(1)) == count_ff;
   assign cnt_clamp  = (int'(cfg.active_workers) > MAX_WORKERS) ?
                       CNT_BITS'(MAX_WORKERS) : CNT_BITS'(cfg.active_workers);
   assign in_range   = int'(req_data.worker_index) < MAX_WORKERS;
   assign best_queued = best_ent_ff[LOAD_BITS +: QUEUE_BITS];

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      chk_in       = chk_ff;
      best_idx_in  = best_idx_ff;
      best_load_in = best_load_ff;
      best_ent_in  = best_ent_ff;
      found_in     = found_ff;
      latch_in     = latch_ff;
      rd_en        = 1'b0;
      rd_addr      = chk_ff + WIDX_BITS'(1);
      wr_en        = 1'b0;
      wr_addr      = best_idx_ff;
      wr_data      = best_ent_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in               = req_data;
               res_in.outcome       = OC_OK;
               res_in.chosen_worker = '0;
               res_in.client_out    = '0;
               res_in.pool_full     = 1'b0;
               state_in             = ST_RESP;
               case (req_data.cmd)
                  CMD_DISPATCH: begin
                     res_in.client_out = req_data.client_handle;
                     if (req_data.client_handle[15]) begin
                        res_in.outcome = OC_INVALID;
                     end else if (!cfg.pool_enabled || latch_ff) begin
                        res_in.outcome = OC_INACTIVE;
                     end else if (cnt_clamp == '0) begin
                        latch_in       = 1'b1;
                        res_in.outcome = OC_ALL_FULL;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        chk_in   = '0;
                        count_in = cnt_clamp;
                        found_in = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_REPORT, CMD_DEQUEUE: begin
                     if (in_range) begin
                        rd_en    = 1'b1;
                        rd_addr  = WIDX_BITS'(req_data.worker_index);
                        state_in = ST_UPD;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rd_data holds the entry at chk_ff; the next one is read meanwhile unless the scan ends
            if (blind_hit) begin
               best_idx_in = chk_ff;
               best_ent_in = rd_data;
               found_in    = 1'b1;
               state_in    = ST_DECIDE;
            end else begin
               if (better) begin
                  best_idx_in  = chk_ff;
                  best_load_in = ent_load;
                  best_ent_in  = rd_data;
                  found_in     = 1'b1;
               end
               if (last) begin
                  state_in = ST_DECIDE;
               end else begin
                  rd_en  = 1'b1;
                  chk_in = chk_ff + WIDX_BITS'(1);
               end
            end
         end
         ST_DECIDE: begin
            if (!found_ff) begin
               latch_in       = 1'b1;
               res_in.outcome = OC_ALL_FULL;
            end else if (best_queued >= cfg.ring_limit) begin
               res_in.outcome = OC_RING_FULL;
            end else begin
               wr_en   = 1'b1;
               wr_data = {best_ent_ff[ENT_BITS-1], best_queued + QUEUE_BITS'(1),
                          best_ent_ff[LOAD_BITS-1:0]};
               res_in.chosen_worker = CHOSEN_BITS'(best_idx_ff);
            end
            state_in = ST_RESP;
         end
         ST_UPD: begin
            wr_en   = 1'b1;
            wr_addr = WIDX_BITS'(req_ff.worker_index);
            if (req_ff.cmd == CMD_REPORT) begin
               wr_data = {req_ff.full_mark, ent_queued, LOAD_BITS'(req_ff.busy_count)};
            end else begin
               wr_data = {ent_full,
                          (ent_queued == '0) ? ent_queued : ent_queued - QUEUE_BITS'(1),
                          ent_active};
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         latch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         latch_ff <= latch_in;
      end
      req_ff       <= req_in;
      res_ff       <= res_in;
      count_ff     <= count_in;
      chk_ff       <= chk_in;
      best_idx_ff  <= best_idx_in;
      best_load_ff <= best_load_in;
      best_ent_ff  <= best_ent_in;
      found_ff     <= found_in;
   end

   assign res_valid = (state_ff == ST_RESP);

   always_comb begin
      res_data           = res_ff;
      res_data.pool_full = latch_ff;
   end

endmodule

`default_nettype wire

### src/lld_checker.sv
// Port-level checks of the least-loaded dispatcher, bound to the top level.
// Depends on lld_pkg and least_loaded_dispatcher_defines.svh.
`default_nettype none
`include "least_loaded_dispatcher_defines.svh"

module lld_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lld_pkg::rsp_type rsp_data
);
   import lld_pkg::*;

   logic seen_full_ff;

   // a delivered item has shown the pool full
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_full_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_data.pool_full) begin
         seen_full_ff <= 1'b1;
      end
   end

   `LLD_ASSERT_RST(a_rsp_idle_after_reset, reset, !rsp_valid)
   `LLD_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `LLD_ASSERT_IMP(a_chosen_only_ok, rsp_valid && (rsp_data.outcome != OC_OK), rsp_data.chosen_worker == '0)
   `LLD_ASSERT_IMP(a_all_full_latches, rsp_valid && (rsp_data.outcome == OC_ALL_FULL), rsp_data.pool_full)
   `LLD_ASSERT_IMP(a_pool_full_sticky, rsp_valid && seen_full_ff, rsp_data.pool_full)

endmodule

bind least_loaded_dispatcher lld_checker u_lld_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
